[rtl/acc_tilt_pkg.sv]
package acc_tilt_pkg;

  // search runs over m = 0..MAX_IDX, m being the distance of the angle from 0 or from 89
  localparam int MAX_IDX   = 44;
  localparam int IDX_W     = 6;
  localparam int NUM_CELLS = IDX_W;
  localparam int SQ_W      = 31;
  localparam int SUM_W     = 32;
  localparam int FRAC_W    = 48;
  localparam int HALF_W    = FRAC_W / 2;
  localparam int PROD_W    = SUM_W + FRAC_W;
  localparam int EXACT_IDX = 30;
  localparam int NINETY    = 90;
  localparam int UPPER_TOP = 89;

  typedef logic [FRAC_W-1:0] tan_t;

  typedef struct packed {
    logic [SUM_W-1:0] mul;
    logic [SUM_W-1:0] rhs;
    logic             upper;
    logic             neg;
    logic             is_zero;
    logic             is_ninety;
    logic [IDX_W-1:0] idx;
  } lane_t;

  // tan^2 of m degrees, unsigned with FRAC_W fraction bits
  function automatic tan_t tan2_entry(input int m);
    real v;
    real t;
    int  hi;
    int  lo;
    t  = $tan(m * 3.14159265358979323846 / 180.0);
    v  = t * t * (2.0 ** FRAC_W);
    hi = $rtoi(v * (2.0 ** (-HALF_W)));
    lo = $rtoi(v - hi * (2.0 ** HALF_W));
    if (lo < 0) begin
      lo = 0;
    end
    return {hi[HALF_W-1:0], lo[HALF_W-1:0]};
  endfunction

  function automatic tan_t tan2_lookup(input logic [IDX_W-1:0] m);
    tan_t r;
    r = '0;
    for (int i = 1; i <= MAX_IDX; i++) begin
      if (int'(m) == i) begin
        r = tan2_entry(i);
      end
    end
    return r;
  endfunction

endpackage

[rtl/accel_tilt_angles.sv]
// path: an accepted input transaction passes stage 0, stage 1, the search cells and the final stage
// throughput: one transaction per cycle; the pipeline holds as a whole while stall_i
//   keeps a finished result waiting in the output register
// reset: rst_ni asynchronous, active low; clears all stage valid bits, no results pending
module accel_tilt_angles (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              stall_o,
  input  logic signed [15:0] accel_x_i,
  input  logic signed [15:0] accel_y_i,
  input  logic signed [15:0] accel_z_i,
  output logic              valid_o,
  input  logic              stall_i,
  output logic signed [7:0] roll_deg_o,
  output logic signed [7:0] pitch_deg_o
);

  localparam int NC   = acc_tilt_pkg::NUM_CELLS;
  localparam int NVLD = 2 * NC + 3;
  localparam int QW   = acc_tilt_pkg::SQ_W;
  localparam int SW   = acc_tilt_pkg::SUM_W;
  localparam int IW   = acc_tilt_pkg::IDX_W;

  // one enable for every stage
  logic en;
  logic [NVLD-1:0] vld_q;

  assign en      = !vld_q[NVLD-1] || !stall_i;
  assign stall_o = !en;
  assign valid_o = vld_q[NVLD-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NVLD-2:0], valid_i};
    end
  end

  // stage 0: squares of the three counts, -32768 squares to 2^30
  logic signed [31:0] sqx, sqy, sqz;
  logic [QW-1:0] sqx_q, sqy_q, sqz_q;
  logic          negx_q, negy_q;

  assign sqx = accel_x_i * accel_x_i;
  assign sqy = accel_y_i * accel_y_i;
  assign sqz = accel_z_i * accel_z_i;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sqx_q  <= sqx[QW-1:0];
      sqy_q  <= sqy[QW-1:0];
      sqz_q  <= sqz[QW-1:0];
      negx_q <= accel_x_i[15];
      negy_q <= accel_y_i[15];
    end
  end

  // stage 1: pick the side of 45 degrees and set up the search operands
  // below 45: largest m with s*tan^2(m) <= a^2, angle m
  // at or above 45: largest m with a^2*tan^2(m) < s, angle 89-m
  function automatic acc_tilt_pkg::lane_t setup(input logic [QW-1:0] a2,
                                                input logic [QW-1:0] o1,
                                                input logic [QW-1:0] o2,
                                                input logic          neg);
    acc_tilt_pkg::lane_t l;
    logic [SW-1:0] s;
    logic [SW-1:0] a;
    s           = SW'(o1) + SW'(o2);
    a           = SW'(a2);
    l.upper     = (a >= s);
    l.mul       = l.upper ? a : s;
    l.rhs       = l.upper ? s : a;
    l.neg       = neg;
    l.is_zero   = (a == '0);
    l.is_ninety = (s == '0);
    l.idx       = '0;
    return l;
  endfunction

  acc_tilt_pkg::lane_t roll_q, pitch_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      roll_q  <= setup(sqx_q, sqy_q, sqz_q, negx_q);
      pitch_q <= setup(sqy_q, sqx_q, sqz_q, negy_q);
    end
  end

  // chain of search cells, one index bit each, most significant first
  acc_tilt_pkg::lane_t roll_c  [NC+1];
  acc_tilt_pkg::lane_t pitch_c [NC+1];

  assign roll_c[0]  = roll_q;
  assign pitch_c[0] = pitch_q;

  for (genvar g = 0; g < NC; g++) begin : g_cell
    acc_tilt_cell #(.BIT(NC - 1 - g)) u_roll (
      .clk_i  (clk_i),
      .en_i   (en),
      .lane_i (roll_c[g]),
      .lane_o (roll_c[g+1])
    );
    acc_tilt_cell #(.BIT(NC - 1 - g)) u_pitch (
      .clk_i  (clk_i),
      .en_i   (en),
      .lane_i (pitch_c[g]),
      .lane_o (pitch_c[g+1])
    );
  end

  // final stage: magnitude from index, then sign of the numerator
  function automatic logic [7:0] finish(input acc_tilt_pkg::lane_t l);
    logic [7:0] mag;
    if (l.is_zero) begin
      mag = '0;
    end else if (l.is_ninety) begin
      mag = 8'(acc_tilt_pkg::NINETY);
    end else if (l.upper) begin
      mag = 8'(acc_tilt_pkg::UPPER_TOP) - 8'(l.idx);
    end else begin
      mag = 8'(l.idx);
    end
    return l.neg ? (8'd0 - mag) : mag;
  endfunction

  logic [7:0] roll_q2, pitch_q2;

  always_ff @(posedge clk_i) begin
    if (en) begin
      roll_q2  <= finish(roll_c[NC]);
      pitch_q2 <= finish(pitch_c[NC]);
    end
  end

  assign roll_deg_o  = roll_q2;
  assign pitch_deg_o = pitch_q2;

endmodule

[rtl/acc_tilt_cell.sv]
module acc_tilt_cell #(
  parameter int BIT = 0
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  acc_tilt_pkg::lane_t  lane_i,
  output acc_tilt_pkg::lane_t  lane_o
);

  localparam int IW = acc_tilt_pkg::IDX_W;
  localparam int HW = acc_tilt_pkg::HALF_W;
  localparam int SW = acc_tilt_pkg::SUM_W;
  localparam int PW = acc_tilt_pkg::PROD_W;

  logic [IW-1:0]       cand;
  logic                in_range;
  acc_tilt_pkg::tan_t  tval;

  acc_tilt_pkg::lane_t lane_q, lane_d, out_q;
  logic [SW+HW-1:0]    plo_q, plo_d, phi_q, phi_d;
  logic [IW-1:0]       cand_q;
  logic                rng_q;

  logic [PW-1:0]       prod;
  logic [PW-1:0]       rv;
  logic [SW+1:0]       rhs3;
  logic [SW+1:0]       mul_x;
  logic                pred;

  // first half: propose the next bit and form the two partial products
  always_comb begin
    cand     = lane_i.idx | IW'(1 << BIT);
    in_range = (cand <= IW'(acc_tilt_pkg::MAX_IDX));
    tval     = in_range ? acc_tilt_pkg::tan2_lookup(cand) : '0;
    plo_d    = lane_i.mul * tval[HW-1:0];
    phi_d    = lane_i.mul * tval[2*HW-1:HW];
    lane_d   = lane_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
      plo_q  <= plo_d;
      phi_q  <= phi_d;
      cand_q <= cand;
      rng_q  <= in_range;
    end
  end

  // second half: compare and keep the bit when the test holds
  always_comb begin
    prod  = {phi_q, {HW{1'b0}}} + PW'(plo_q);
    rv    = {lane_q.rhs, {acc_tilt_pkg::FRAC_W{1'b0}}};
    rhs3  = (SW+2)'(lane_q.rhs) * (SW+2)'(3);
    mul_x = (SW+2)'(lane_q.mul);
    if (cand_q == IW'(acc_tilt_pkg::EXACT_IDX)) begin
      // tan^2 of 30 degrees is one third, tested exactly
      pred = lane_q.upper ? (mul_x < rhs3) : (mul_x <= rhs3);
    end else begin
      pred = lane_q.upper ? (prod < rv) : (prod <= rv);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q <= lane_q;
      if (rng_q && pred) begin
        out_q.idx <= cand_q;
      end
    end
  end

  assign lane_o = out_q;

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    bit                 drain;  // hold back until every pending angle pair has come out
  } sample_t;

  typedef struct {
    logic signed [7:0] roll;
    logic signed [7:0] pitch;
  } angles_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic valid_i = 1'b0;
  logic stall_o;
  logic signed [15:0] accel_x_i = '0;
  logic signed [15:0] accel_y_i = '0;
  logic signed [15:0] accel_z_i = '0;
  logic valid_o;
  logic stall_i = 1'b0;
  logic signed [7:0] roll_deg_o;
  logic signed [7:0] pitch_deg_o;

  sample_t pending_samples[$];
  angles_t pending_angles[$];
  sample_t cur_sample;

  // squared sine and cosine of whole degrees, unsigned q63
  bit [63:0] sin_sq[90];
  bit [63:0] cos_sq[90];

  int  send_wait;
  int  hold_cnt;
  int  idle_cycles;
  int  errors;
  bit  send_busy_mode;
  bit  recv_busy_mode;

  accel_tilt_angles dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (valid_i),
    .stall_o    (stall_o),
    .accel_x_i  (accel_x_i),
    .accel_y_i  (accel_y_i),
    .accel_z_i  (accel_z_i),
    .valid_o    (valid_o),
    .stall_i    (stall_i),
    .roll_deg_o (roll_deg_o),
    .pitch_deg_o(pitch_deg_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit [63:0] q63_mul(input bit [63:0] a, input bit [63:0] b);
    bit [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[126:63];
  endfunction

  // arctangent of 1/n in q63 by the alternating series
  function automatic bit [63:0] arctan_inv(input bit [63:0] n);
    bit [63:0] p;
    bit [63:0] acc;
    bit [63:0] term;
    p = (64'd1 << 63) / n;
    acc = '0;
    for (int i = 0; i < 64 && p != 0; i++) begin
      term = p / (2 * i + 1);
      if (i % 2 == 0) begin
        acc = acc + term;
      end else begin
        acc = acc - term;
      end
      p = p / (n * n);
    end
    return acc;
  endfunction

  task automatic build_trig_table();
    bit [63:0] one_deg;
    bit [63:0] sn[46];
    bit [63:0] cs[46];
    bit [63:0] ang;
    bit [63:0] t;
    bit [63:0] sv;
    bit [63:0] cv;
    one_deg = (4 * arctan_inv(5) - arctan_inv(239)) / 45;
    for (int k = 0; k <= 45; k++) begin
      ang = k * one_deg;
      t = 64'd1 << 63;
      sv = '0;
      cv = 64'd1 << 63;
      for (int n = 1; n <= 40; n++) begin
        t = q63_mul(t, ang) / n;
        case (n % 4)
          1: sv = sv + t;
          2: cv = cv - t;
          3: sv = sv - t;
          default: cv = cv + t;
        endcase
      end
      sn[k] = sv;
      cs[k] = cv;
    end
    for (int k = 1; k < 90; k++) begin
      sv = (k <= 45) ? sn[k] : cs[90 - k];
      cv = (k <= 45) ? cs[k] : sn[90 - k];
      sin_sq[k] = q63_mul(sv, sv);
      cos_sq[k] = q63_mul(cv, cv);
    end
  endtask

  // truncated angle in degrees of num over the magnitude of (o1, o2)
  function automatic logic signed [7:0] tilt_deg(input int num, input int o1, input int o2);
    longint a2;
    longint s;
    int     mag;
    bit     found;
    bit [127:0] lhs;
    bit [127:0] rhs;
    a2 = longint'(num) * num;
    s = longint'(o1) * o1 + longint'(o2) * o2;
    mag = 0;
    found = 1'b0;
    if (a2 == 0) begin
      mag = 0;
    end else if (s == 0) begin
      mag = 90;
    end else begin
      for (int k = 89; k >= 1 && !found; k--) begin
        if (k == 45) begin
          found = (a2 >= s);
        end else begin
          lhs = {64'd0, 64'(a2)} * {64'd0, cos_sq[k]};
          rhs = {64'd0, 64'(s)} * {64'd0, sin_sq[k]};
          found = (lhs >= rhs);
        end
        if (found) begin
          mag = k;
        end
      end
    end
    return 8'(num < 0 ? -mag : mag);
  endfunction

  function automatic int draw_wait(input bit busy_mode);
    if (!busy_mode) begin
      return 0;
    end
    return $urandom_range(0, 14);
  endfunction

  function automatic logic signed [15:0] rand_axis();
    case ($urandom_range(0, 5))
      0, 1: return 16'($urandom);
      2: return 16'($signed($urandom_range(0, 4096)) - 2048);
      3: return 16'($signed($urandom_range(0, 32768)) - 16384);
      4: return ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
      default: return 16'($signed($urandom_range(0, 16)) - 8);
    endcase
  endfunction

  task automatic add_sample(input int x, input int y, input int z, input bit drain);
    sample_t s;
    s.x = 16'(x);
    s.y = 16'(y);
    s.z = 16'(z);
    s.drain = drain;
    pending_samples.push_back(s);
  endtask

  // driver: presents queued samples, honors stall_o and its own gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_i <= 1'b0;
      send_wait = 0;
    end else if (!valid_i || !stall_o) begin
      if (valid_i) begin
        // transaction accepted: predict its angle pair
        pending_angles.push_back('{roll:  tilt_deg(cur_sample.x, cur_sample.y, cur_sample.z),
                                   pitch: tilt_deg(cur_sample.y, cur_sample.x, cur_sample.z)});
        if ($urandom_range(0, 99) == 0) begin
          send_busy_mode = ~send_busy_mode;
        end
      end
      if (send_wait > 0) begin
        send_wait--;
        valid_i <= 1'b0;
      end else if (pending_samples.size() > 0 &&
                   !(pending_samples[0].drain && pending_angles.size() > 0)) begin
        cur_sample = pending_samples.pop_front();
        valid_i <= 1'b1;
        accel_x_i <= cur_sample.x;
        accel_y_i <= cur_sample.y;
        accel_z_i <= cur_sample.z;
        send_wait = draw_wait(send_busy_mode);
      end else begin
        valid_i <= 1'b0;
      end
    end
  end

  // monitor: checks each result transaction against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_i <= 1'b0;
      hold_cnt = 0;
    end else begin
      if (valid_o && !stall_i) begin
        if (pending_angles.size() == 0) begin
          $display("%0t: unexpected result roll %0d pitch %0d", $time, roll_deg_o,
                   pitch_deg_o);
          errors++;
        end else begin
          angles_t want;
          want = pending_angles.pop_front();
          if (roll_deg_o !== want.roll) begin
            $display("%0t: roll mismatch expected %0d actual %0d", $time, want.roll,
                     roll_deg_o);
            errors++;
          end
          if (pitch_deg_o !== want.pitch) begin
            $display("%0t: pitch mismatch expected %0d actual %0d", $time, want.pitch,
                     pitch_deg_o);
            errors++;
          end
        end
        if ($urandom_range(0, 99) == 0) begin
          recv_busy_mode = ~recv_busy_mode;
        end
        hold_cnt = draw_wait(recv_busy_mode);
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        stall_i <= 1'b1;
      end else begin
        stall_i <= 1'b0;
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk_i) begin
    if ((valid_i && !stall_o) || (valid_o && !stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= 5000) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    errors = 0;
    idle_cycles = 0;
    send_busy_mode = 1'b1;
    recv_busy_mode = 1'b1;
    build_trig_table();

    // directed: zero sample, lone axes, extremes, exact 45 degrees
    add_sample(0, 0, 0, 0);
    add_sample(0, 0, 16384, 0);
    add_sample(0, 0, -32768, 0);
    add_sample(32767, 0, 0, 0);
    add_sample(-32768, 0, 0, 0);
    add_sample(0, 32767, 0, 0);
    add_sample(0, -32768, 0, 0);
    add_sample(-32768, -32768, -32768, 0);
    add_sample(32767, 32767, 32767, 0);
    add_sample(-32768, 32767, 0, 0);
    add_sample(5, 3, 4, 0);
    add_sample(-5, 4, -3, 0);
    add_sample(1000, 1000, 0, 0);
    add_sample(-1000, 0, 1000, 0);
    add_sample(1, 0, 0, 0);
    add_sample(1, 1, 1, 0);
    add_sample(-1, -1, 0, 0);
    add_sample(16384, -16384, 0, 1);
    add_sample(12, -7, 16000, 0);
    add_sample(28377, 0, 16384, 0);

    for (int i = 0; i < 2000; i++) begin
      add_sample(rand_axis(), rand_axis(), rand_axis(), (i % 500) == 250);
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_samples.size() > 0 || valid_i || pending_angles.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (30) @(posedge clk_i);

    if (errors == 0 && pending_angles.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
